// ===== design/ledenc_pkg.sv =====
// shared types, constants and helpers for the addressable led bit encoder
// no dependencies; imported by the top level, ledenc_seq and the testbench

package ledenc_pkg;

	localparam int PIXEL_COUNT     = 64;
	localparam int BYTES_PER_PIXEL = 3;
	localparam int RESET_SLOTS     = 50;

	localparam int PIX_AW  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int BYTE_W  = 2;
	localparam int GAP_W   = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;
	localparam int PIXEL_W = BYTES_PER_PIXEL * 8;

	localparam logic [7:0] GREEN_SCALE     = 8'hB0;
	localparam logic [7:0] BLUE_SCALE      = 8'hF0;
	localparam logic [7:0] ZERO_DUTY_RESET = 8'd29;
	localparam logic [2:0] BIT_MSB         = 3'd7;

	// byte positions inside a stored pixel word (wire order)
	localparam logic [BYTE_W-1:0] BYTE_GREEN = 2'd0;
	localparam logic [BYTE_W-1:0] BYTE_RED   = 2'd1;
	localparam logic [BYTE_W-1:0] BYTE_BLUE  = 2'd2;
	localparam logic [BYTE_W-1:0] BYTE_WHITE = 2'd3;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_START = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	// frame sequencer status seen by the datapath
	typedef struct packed {
		logic              active;
		logic              in_gap;
		logic              last_slot;
		logic [PIX_AW-1:0] pix;
		logic [BYTE_W-1:0] byte_sel;
		logic [2:0]        bit_sel;
	} slot_t;

	function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [7:0] f);
		logic [15:0] prod;
		prod = 16'(v) * 16'(f);
		return prod[15:8];
	endfunction

endpackage

// ===== design/addressable_led_bit_encoder.sv =====
// addressable led bit encoder top level: pixel store, frame sequencer, duty slot output
// depends on ledenc_pkg, ledenc_ram, ledenc_seq
// pipeline: an accepted input transaction is registered in stage 1 while the ram read runs, then in the result register
// throughput: one input transaction per cycle, set by the ram read port, while the sink does not hold the result
// reset: control, frame state and per-pixel valid bits clear at once; no clearing pass,
// a pixel never written since reset reads as zero through its valid bit

module addressable_led_bit_encoder (
	input  logic              clk,
	input  logic              arst_n,
	// input item stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,  // pixel_index[5:0], red, green, blue, white, zero pad
	input  ledenc_pkg::op_t   s_tuser,  // operation
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,  // read_color[31:0], busy_refused, duty_value[8:0], pad
	output logic              m_tuser,  // duty_valid
	output logic              m_tlast,  // frame_last
	// zero bit duty register write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	import ledenc_pkg::*;

	// input fields
	logic [5:0] pixel_index;
	logic [7:0] red, green, blue, white;
	logic       accept;
	logic       advance;
	logic       px_ok;

	// sequencer and store
	slot_t              seq_status;
	logic               start_en, tick_en;
	logic               ram_we;
	logic [PIXEL_W-1:0] ram_wdata;
	logic [PIXEL_W-1:0] ram_rdata;
	logic [PIX_AW-1:0]  px_addr;
	logic [PIX_AW-1:0]  ram_raddr;
	logic [PIXEL_COUNT-1:0] pix_valid_q;

	logic [7:0] zero_duty_q;

	// stage 1: decoded item, ram read in flight
	logic              v_s1;
	op_t               op_s1;
	logic              refused_s1;
	logic              tick_s1;
	logic              data_slot_s1;
	logic              last_s1;
	logic              ok_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [2:0]        bit_s1;

	// result register
	logic        out_v_q;
	logic [31:0] color_q;
	logic        refused_q;
	logic [8:0]  duty_q;
	logic        duty_valid_q;
	logic        last_q;

	// result logic
	logic [7:0]  slot_byte;
	logic        slot_bit;
	logic [31:0] color_d;
	logic [8:0]  duty_d;

	assign pixel_index = s_tdata[5:0];
	assign red         = s_tdata[13:6];
	assign green       = s_tdata[21:14];
	assign blue        = s_tdata[29:22];
	assign white       = s_tdata[37:30];

	// whole pipe moves unless the result register is held by the sink
	assign advance  = !out_v_q || m_tready;
	assign s_tready = advance;
	assign accept   = s_tvalid && s_tready;

	assign px_ok   = (32'(pixel_index) < PIXEL_COUNT);
	assign px_addr = PIX_AW'(pixel_index);

	// config register: the user must write only while idle, the block itself does not enforce it; writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_duty_q <= ZERO_DUTY_RESET;
		end else if (cfg_valid) begin
			zero_duty_q <= cfg_data;
		end
	end

	assign start_en = accept && (s_tuser == OP_START);
	assign tick_en  = accept && (s_tuser == OP_TICK);

	ledenc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start_en (start_en),
		.tick_en  (tick_en),
		.status   (seq_status)
	);

	// pixel write: refused while a frame is being sent
	assign ram_we = accept && (s_tuser == OP_WRITE) && !seq_status.active && px_ok;

	always_comb begin
		ram_wdata = '0;
		ram_wdata[8*BYTE_GREEN +: 8] = scale_byte(green, GREEN_SCALE);
		ram_wdata[8*BYTE_RED   +: 8] = red;
		ram_wdata[8*BYTE_BLUE  +: 8] = scale_byte(blue, BLUE_SCALE);
		if (BYTES_PER_PIXEL == 4) begin
			ram_wdata[PIXEL_W-1 -: 8] = white;
		end
	end

	// the single read port serves either a pixel read or the slot being sent
	assign ram_raddr = (s_tuser == OP_TICK) ? seq_status.pix : px_addr;

	ledenc_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (PIXEL_COUNT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (px_addr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one valid bit per pixel stands in for clearing the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= '0;
		end else if (ram_we) begin
			pix_valid_q[px_addr] <= 1'b1;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= s_tuser;
			refused_s1   <= seq_status.active
				&& ((s_tuser == OP_WRITE) || (s_tuser == OP_START));
			tick_s1      <= seq_status.active && (s_tuser == OP_TICK);
			data_slot_s1 <= !seq_status.in_gap;
			last_s1      <= seq_status.active && (s_tuser == OP_TICK)
				&& seq_status.last_slot;
			// out of range or never written reads as zero
			ok_s1        <= pix_valid_q[ram_raddr] && ((s_tuser == OP_TICK) || px_ok);
			byte_s1      <= seq_status.byte_sel;
			bit_s1       <= seq_status.bit_sel;
		end
	end

	// result logic
	always_comb begin
		slot_byte = ram_rdata[8*byte_s1 +: 8];
		slot_bit  = ok_s1 && slot_byte[bit_s1];

		color_d = '0;
		if ((op_s1 == OP_READ) && ok_s1) begin
			color_d[23:16] = ram_rdata[8*BYTE_RED   +: 8];
			color_d[15:8]  = ram_rdata[8*BYTE_GREEN +: 8];
			color_d[7:0]   = ram_rdata[8*BYTE_BLUE  +: 8];
			if (BYTES_PER_PIXEL == 4) begin
				color_d[31:24] = ram_rdata[PIXEL_W-1 -: 8];
			end
		end

		// one bit doubles the zero-bit compare value; gap slots are zero
		duty_d = '0;
		if (tick_s1 && data_slot_s1) begin
			duty_d = slot_bit ? {zero_duty_q, 1'b0} : {1'b0, zero_duty_q};
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= v_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			color_q      <= color_d;
			refused_q    <= refused_s1;
			duty_q       <= duty_d;
			duty_valid_q <= tick_s1;
			last_q       <= last_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, duty_q, refused_q, color_q};
	assign m_tuser  = duty_valid_q;
	assign m_tlast  = last_q;

endmodule

// ===== design/ledenc_ram.sv =====
// generic single write port, single read port ram with registered read
// no package dependencies

module ledenc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/ledenc_seq.sv =====
// frame sequencer: walks pixel, byte and bit msb first, then the reset gap
// depends on ledenc_pkg

module ledenc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start_en,
	input  logic              tick_en,
	output ledenc_pkg::slot_t status
);
	import ledenc_pkg::*;

	logic              active_q;
	logic              in_gap_q;
	logic [PIX_AW-1:0] pix_q;
	logic [BYTE_W-1:0] byte_q;
	logic [2:0]        bit_q;
	logic [GAP_W-1:0]  gap_q;
	logic              gap_end;

	assign gap_end = (gap_q == GAP_W'(RESET_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			in_gap_q <= 1'b0;
			pix_q    <= '0;
			byte_q   <= '0;
			bit_q    <= BIT_MSB;
			gap_q    <= '0;
		end else if (start_en && !active_q) begin
			active_q <= 1'b1;
			in_gap_q <= 1'b0;
			pix_q    <= '0;
			byte_q   <= '0;
			bit_q    <= BIT_MSB;
			gap_q    <= '0;
		end else if (tick_en && active_q) begin
			if (!in_gap_q) begin
				bit_q <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					if (byte_q == BYTE_W'(BYTES_PER_PIXEL - 1)) begin
						byte_q <= '0;
						if (pix_q == PIX_AW'(PIXEL_COUNT - 1)) begin
							pix_q    <= '0;
							in_gap_q <= 1'b1;
						end else begin
							pix_q <= pix_q + PIX_AW'(1);
						end
					end else begin
						byte_q <= byte_q + BYTE_W'(1);
					end
				end
			end else if (gap_end) begin
				active_q <= 1'b0;
				in_gap_q <= 1'b0;
				gap_q    <= '0;
			end else begin
				gap_q <= gap_q + GAP_W'(1);
			end
		end
	end

	assign status.active    = active_q;
	assign status.in_gap    = in_gap_q;
	assign status.last_slot = in_gap_q && gap_end;
	assign status.pix       = pix_q;
	assign status.byte_sel  = byte_q;
	assign status.bit_sel   = bit_q;

endmodule

// ===== design/ledenc_chk.sv =====
// port-level checks for the addressable led bit encoder, bound to the top level
// depends only on the top level's ports

module ledenc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled result transaction holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// the frame end marker sits on a reset gap slot
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser && (m_tdata[41:33] == 9'd0))
		else $error("frame end not on a zero duty slot");

	// a slot is never also a refusal and carries no color
	a_slot_not_refused: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tdata[32] && (m_tdata[31:0] == 32'd0))
		else $error("slot carries refusal or color");

	// refusals carry neither color nor duty and never mark a frame end
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> (m_tdata[31:0] == 32'd0)
			&& (m_tdata[41:33] == 9'd0) && !m_tlast)
		else $error("refusal carries data");

endmodule

bind addressable_led_bit_encoder ledenc_chk u_ledenc_chk (.*);

// ===== sim/addressable_led_bit_encoder_tb.sv =====
// self-checking testbench for addressable_led_bit_encoder: pixel writes and reads, frame start,
// duty slot ticks, checked against a built-in predictor of the pixel store and frame sequencer
// depends on ledenc_pkg and the addressable_led_bit_encoder rtl
`timescale 1ns / 1ps

module addressable_led_bit_encoder_tb;
	import ledenc_pkg::*;

	localparam int STORE_BYTES = PIXEL_COUNT * BYTES_PER_PIXEL;
	localparam int DATA_SLOTS  = STORE_BYTES * 8;
	localparam int TOTAL_SLOTS = DATA_SLOTS + RESET_SLOTS;
	localparam int HOLD_AT     = 150;  // results seen before the long receiver hold-off
	localparam int HOLD_LEN    = 200;  // length of that hold-off in cycles

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one input transaction
	typedef struct packed {
		op_t        op;
		logic [5:0] px;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] white;
	} led_cmd_t;

	// one result transaction
	typedef struct packed {
		logic [31:0] color;
		logic        refused;
		logic [8:0]  duty;
		logic        dvalid;
		logic        last;
	} led_res_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	// dut ports
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;  // pixel_index[5:0], red, green, blue, white, zero pad
	op_t         s_tuser   = OP_WRITE;  // operation
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;  // read_color[31:0], busy_refused, duty_value[8:0], pad
	logic        m_tuser;  // duty_valid
	logic        m_tlast;  // frame_last
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	addressable_led_bit_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// traffic bookkeeping
	led_cmd_t   cmd_queue[$];         // commands not yet offered to the dut
	led_res_t   expected_results[$];  // predicted results in order
	led_cmd_t   cmd_on_bus;
	idle_mode_t idle_mode      = IDLE_NONE;
	int         mismatch_count = 0;
	int         results_seen   = 0;
	int         hold_left      = 0;
	bit         hold_done      = 1'b0;

	// predictor state: pixel store, frame sequencer, duty register
	logic [7:0]  led_store [STORE_BYTES];
	bit          frame_on  = 1'b0;
	logic [10:0] slot_idx  = '0;
	logic [7:0]  duty_reg  = ZERO_DUTY_RESET;

	// frame tracker used only while building stimulus: slots left in the frame
	int gen_slots_left = 0;

	initial begin
		foreach (led_store[i]) led_store[i] = 8'h00;
	end

	// predict the result of one accepted command and advance the model state
	function automatic led_res_t encode_step(led_cmd_t c);
		led_res_t    r;
		int unsigned base;
		logic [15:0] prod;
		logic        bit_val;
		r = '0;
		base = c.px * BYTES_PER_PIXEL;
		case (c.op)
			OP_WRITE: begin
				if (frame_on) begin
					// store is frozen while a frame goes out
					r.refused = 1'b1;
				end else if (c.px < PIXEL_COUNT) begin
					prod = c.green * GREEN_SCALE;
					led_store[base] = prod[15:8];
					led_store[base + 1] = c.red;
					prod = c.blue * BLUE_SCALE;
					led_store[base + 2] = prod[15:8];
					if (BYTES_PER_PIXEL == 4) led_store[base + 3] = c.white;
				end
			end
			OP_READ: begin
				// reads are answered even during a frame
				if (c.px < PIXEL_COUNT) begin
					r.color = {8'h00, led_store[base + 1], led_store[base], led_store[base + 2]};
					if (BYTES_PER_PIXEL == 4) r.color[31:24] = led_store[base + 3];
				end
			end
			OP_START: begin
				if (frame_on) begin
					r.refused = 1'b1;
				end else begin
					frame_on = 1'b1;
					slot_idx = '0;
				end
			end
			default: begin
				// a tick only emits a slot inside a frame
				if (frame_on) begin
					r.dvalid = 1'b1;
					if (slot_idx < DATA_SLOTS) begin
						bit_val = led_store[slot_idx >> 3][BIT_MSB - slot_idx[2:0]];
						r.duty = bit_val ? {duty_reg, 1'b0} : {1'b0, duty_reg};
					end
					if (slot_idx + 1 >= TOTAL_SLOTS) begin
						r.last = 1'b1;
						frame_on = 1'b0;
						slot_idx = '0;
					end else begin
						slot_idx = slot_idx + 1'b1;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic int sender_idle_pct();
		case (idle_mode)
			IDLE_SENDER: return 59;
			IDLE_BOTH:   return 26;
			default:     return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct();
		case (idle_mode)
			IDLE_RECEIVER: return 59;
			IDLE_BOTH:     return 26;
			default:       return 0;
		endcase
	endfunction

	task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// driver: offers queued commands, predicts each one as its transaction completes
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(encode_step(cmd_on_bus));
			end
			// a new command may go out once the bus is free or the current one is taken
			if (!s_tvalid || s_tready) begin
				if (cmd_queue.size() != 0 && !roll(sender_idle_pct())) begin
					cmd_on_bus = cmd_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, cmd_on_bus.white, cmd_on_bus.blue, cmd_on_bus.green,
						cmd_on_bus.red, cmd_on_bus.px};
					s_tuser  <= cmd_on_bus.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, so the dut backs up and stalls its input
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	// monitor: compares every result transaction with the oldest prediction
	always @(posedge clk) begin
		led_res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					note_mismatch("unexpected result", m_tdata[31:0], '0);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[31:0] !== want.color)
						note_mismatch("read_color", m_tdata[31:0], want.color);
					if (m_tdata[32] !== want.refused)
						note_mismatch("busy_refused", m_tdata[32], want.refused);
					if (m_tdata[41:33] !== want.duty)
						note_mismatch("duty_value", m_tdata[41:33], want.duty);
					if (m_tuser !== want.dvalid)
						note_mismatch("duty_valid", m_tuser, want.dvalid);
					if (m_tlast !== want.last)
						note_mismatch("frame_last", m_tlast, want.last);
				end
			end
			m_tready <= (hold_left == 0) && !roll(receiver_stall_pct());
		end
	end

	// queue a command and keep the stimulus-side frame tracker in step
	task automatic add_cmd(led_cmd_t c);
		if (c.op == OP_START && gen_slots_left == 0) gen_slots_left = TOTAL_SLOTS;
		else if (c.op == OP_TICK && gen_slots_left > 0) gen_slots_left--;
		cmd_queue.push_back(c);
	endtask

	task automatic add_fixed(op_t op, logic [5:0] px, logic [7:0] r, logic [7:0] g,
		logic [7:0] b, logic [7:0] w);
		led_cmd_t c;
		c = '{op: op, px: px, red: r, green: g, blue: b, white: w};
		add_cmd(c);
	endtask

	task automatic add_random(op_t op);
		led_cmd_t c;
		c.op    = op;
		c.px    = 6'($urandom);
		c.red   = 8'($urandom);
		c.green = 8'($urandom);
		c.blue  = 8'($urandom);
		c.white = 8'($urandom);
		// now and then saturate or blank the colors
		if (roll(10)) {c.red, c.green, c.blue, c.white} = '1;
		else if (roll(10)) {c.red, c.green, c.blue, c.white} = '0;
		add_cmd(c);
	endtask

	// store traffic outside a frame: writes, reads and ticks that emit nothing
	task automatic add_store_mix(int count);
		int k;
		repeat (count) begin
			k = $urandom_range(99);
			if (k < 45) add_random(OP_WRITE);
			else if (k < 85) add_random(OP_READ);
			else add_random(OP_TICK);
		end
	endtask

	// fill the store, start a frame if none runs, then tick through it; a cut frame
	// is left running into the next phase
	task automatic add_frame_phase(bit run_to_end);
		int ticks;
		int k;
		if (gen_slots_left == 0) begin
			add_store_mix(100);
			add_random(OP_START);
		end
		ticks = 0;
		while (gen_slots_left > 0 && (run_to_end || ticks < 200)) begin
			if (roll(90)) begin
				add_random(OP_TICK);
				ticks++;
			end else begin
				// refused writes and starts, normal reads, in the middle of a frame
				k = $urandom_range(2);
				if (k == 0) add_random(OP_WRITE);
				else if (k == 1) add_random(OP_READ);
				else add_random(OP_START);
			end
		end
		if (gen_slots_left == 0) add_store_mix(30);
	endtask

	task automatic add_directed();
		add_fixed(OP_READ,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00);  // untouched pixel reads zero
		add_fixed(OP_TICK,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00);  // tick with no frame
		add_fixed(OP_WRITE, 6'd0,  8'hFF, 8'hFF, 8'hFF, 8'hFF);  // full scale on every channel
		add_fixed(OP_READ,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00);
		add_fixed(OP_WRITE, 6'd63, 8'h80, 8'h01, 8'h80, 8'h00);  // last pixel, scaling floor
		add_fixed(OP_READ,  6'd63, 8'h00, 8'h00, 8'h00, 8'h00);
		add_fixed(OP_WRITE, 6'd1,  8'h00, 8'h00, 8'h00, 8'hFF);  // white dropped on 3-byte pixels
		add_fixed(OP_READ,  6'd1,  8'h00, 8'h00, 8'h00, 8'h00);
		add_fixed(OP_WRITE, 6'd2,  8'hA5, 8'h5A, 8'hC3, 8'h3C);
		add_fixed(OP_READ,  6'd2,  8'h00, 8'h00, 8'h00, 8'h00);
		add_fixed(OP_START, 6'd0,  8'h00, 8'h00, 8'h00, 8'h00);
		add_fixed(OP_START, 6'd0,  8'h00, 8'h00, 8'h00, 8'h00);  // refused, frame keeps going
		add_fixed(OP_WRITE, 6'd3,  8'h11, 8'h22, 8'h33, 8'h44);  // refused during frame
		add_fixed(OP_READ,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00);  // allowed during frame
		repeat (4) add_fixed(OP_TICK, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00);
	endtask

	// register write, only with no transaction in flight
	task automatic write_duty(logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		duty_reg = value;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
		// let the pipeline settle
		repeat (4) @(posedge clk);
	endtask

	// phase plan: idling style, duty setting, and whether the frame runs to its end
	idle_mode_t phase_mode [4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
	logic [7:0] phase_duty [4] = '{ZERO_DUTY_RESET, 8'd255, 8'd1, 8'd0};
	bit         phase_full [4] = '{1'b1, 1'b0, 1'b1, 1'b1};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// phase 0 runs on the reset duty; later writes land mid-frame in phase 2
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			if (ph > 0) write_duty(phase_duty[ph]);
			@(negedge clk);
			idle_mode = phase_mode[ph];
			if (ph == 0) add_directed();
			add_frame_phase(phase_full[ph]);
		end
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

endmodule
